// ----- rtl/hill_cipher_2x2_mod26_macros.svh -----
// Assertion macros for the Hill cipher block.
// Both take a label, a property expression and a message string.
`ifndef HILL_CIPHER_2X2_MOD26_MACROS_SVH
`define HILL_CIPHER_2X2_MOD26_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define HCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HCM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define HCM_ASSERT(label, prop, msg)
`define HCM_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- rtl/hcm_pkg.sv -----
package hcm_pkg;

  // Alphabet size and the reciprocal used for reduction by multiplication.
  localparam int MODULUS  = 26;
  localparam int RECIP_26 = (65536 + MODULUS - 1) / MODULUS;

  // Letter used to pad an unfinished block when encrypting ('z').
  localparam logic [4:0] PAD_LETTER = 5'd25;

  // Cycles the derived key pipeline needs after reset or a register write.
  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_KEY_A,
    REG_KEY_B,
    REG_KEY_C,
    REG_KEY_D,
    REG_DECRYPT_MODE
  } cfg_reg_t;

  // Effective key matrix [k00 k01; k10 k11] stored as k[0..3], plus status.
  typedef struct packed {
    logic [3:0][4:0] k;
    logic            err;
    logic            decrypt;
    logic            ready;
  } key_t;

  // One plaintext or ciphertext block, row major, with the message end mark.
  typedef struct packed {
    logic [3:0][4:0] p;
    logic            eom;
  } blk_t;

  // Four result letters of a block ready for output.
  typedef struct packed {
    logic [3:0][4:0] c;
    logic            eom;
    logic            err;
  } res_t;

  // Inverse lookup result.
  typedef struct packed {
    logic       ok;
    logic [4:0] val;
  } inv_t;

  // Reduce a value below 2048 modulo 26 by reciprocal multiplication.
  function automatic logic [4:0] mod26(input logic [10:0] v);
    logic [22:0] prod;
    logic [6:0]  q;
    logic [10:0] r;
    prod = 23'(v) * 23'(RECIP_26);
    q    = prod[22:16];
    r    = v - 11'(q) * 11'(MODULUS);
    return r[4:0];
  endfunction

  // Fold a 5-bit value into 0..25.
  function automatic logic [4:0] red26(input logic [4:0] v);
    return (v >= 5'(MODULUS)) ? v - 5'(MODULUS) : v;
  endfunction

  // Multiplicative inverse modulo 26, for values 0..25.
  function automatic inv_t inv26(input logic [4:0] v);
    inv_t r;
    r.ok = 1'b1;
    unique case (v)
      5'd1:    r.val = 5'd1;
      5'd3:    r.val = 5'd9;
      5'd5:    r.val = 5'd21;
      5'd7:    r.val = 5'd15;
      5'd9:    r.val = 5'd3;
      5'd11:   r.val = 5'd19;
      5'd15:   r.val = 5'd7;
      5'd17:   r.val = 5'd23;
      5'd19:   r.val = 5'd11;
      5'd21:   r.val = 5'd5;
      5'd23:   r.val = 5'd17;
      5'd25:   r.val = 5'd25;
      default: begin
        r.ok  = 1'b0;
        r.val = 5'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/hill_cipher_2x2_mod26.sv -----
// The block, sum and output registers lie between the request that completes a block and
// its first result. Throughput: one letter per cycle while not back-pressured; each block
// leaves as four results, one per cycle while taken, set by the single output register.
// Reset: synchronous, active high; key returns to [3 2; 5 7], encrypt mode, empty block.
// The derived key pipeline refills after reset or a register write, with no request
// accepted until the settle counter has run down.
`include "hill_cipher_2x2_mod26_macros.svh"

module hill_cipher_2x2_mod26 (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  logic       s_axis_tlast,   // end_of_message
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [4:0] out_letter, [7:5] zero
  output logic [1:0] m_axis_tuser,   // [0] block_last, [1] key_error
  output logic       m_axis_tlast    // message_last
);

  hcm_pkg::key_t key;
  hcm_pkg::blk_t blk;
  hcm_pkg::res_t res;
  logic          blk_valid, blk_ready;
  logic          res_valid, res_ready;
  logic [4:0]    out_letter;
  logic          block_last, key_error;

  // Key registers and derived key.
  hcm_key u_key (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  // Letter collection into blocks.
  hcm_collect u_collect (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .letter         (s_axis_tdata[4:0]),
    .end_of_message (s_axis_tlast),
    .key            (key),
    .blk_valid      (blk_valid),
    .blk_ready      (blk_ready),
    .blk            (blk)
  );

  // Matrix product.
  hcm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk),
    .key       (key),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Result serializer.
  hcm_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_letter   (out_letter),
    .block_last   (block_last),
    .message_last (m_axis_tlast),
    .key_error    (key_error)
  );

  assign m_axis_tdata = {3'b000, out_letter};
  assign m_axis_tuser = {key_error, block_last};

  // No request is taken while the derived key is settling.
  `HCM_ASSERT_ALWAYS(a_no_accept_settling, !key.ready |-> !s_axis_tready, "request taken while key settles")
  // The message end only falls on the last letter of a block.
  `HCM_ASSERT(a_tlast_on_block_end, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0], "message end inside a block")
  // A key error is only reported in decrypt mode.
  `HCM_ASSERT(a_err_decrypt_only, m_axis_tvalid && m_axis_tuser[1] |-> key.decrypt, "key error in encrypt mode")
  // A block once started keeps its results coming.
  `HCM_ASSERT(a_block_continues, m_axis_tvalid && m_axis_tready && !m_axis_tuser[0] |=> m_axis_tvalid, "block cut short")

endmodule

// ----- rtl/hcm_key.sv -----
module hcm_key (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [4:0]        cfg_data,
  output hcm_pkg::key_t     key
);

  logic [4:0] key_a, key_b, key_c, key_d;
  logic       decrypt_mode;
  logic [2:0] settle;

  logic [4:0] s1_a, s1_b, s1_c, s1_d;
  logic [9:0] s1_ad, s1_bc;

  logic [4:0] s2_a, s2_b, s2_c, s2_d;
  logic [4:0] s2_di;
  logic       s2_ok;

  logic [3:0][9:0] s3_prod;
  logic [3:0][4:0] s3_k;
  logic            s3_ok;

  logic [3:0][4:0] s4_k;
  logic            s4_err;

  logic [4:0]      ra, rb, rc, rd;
  logic [4:0]      det;
  hcm_pkg::inv_t   inv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_a        <= 5'd3;
      key_b        <= 5'd2;
      key_c        <= 5'd5;
      key_d        <= 5'd7;
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (hcm_pkg::cfg_reg_t'(cfg_index))
        hcm_pkg::REG_KEY_A:        key_a <= cfg_data;
        hcm_pkg::REG_KEY_B:        key_b <= cfg_data;
        hcm_pkg::REG_KEY_C:        key_c <= cfg_data;
        hcm_pkg::REG_KEY_D:        key_d <= cfg_data;
        hcm_pkg::REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Settle counter: the derived key is valid once it has run down.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= hcm_pkg::SETTLE_CYCLES;
    end else if (settle != 3'd0) begin
      settle <= settle - 3'd1;
    end
  end

  // Stage 1: fold the key entries and form the determinant products.
  assign ra = hcm_pkg::red26(key_a);
  assign rb = hcm_pkg::red26(key_b);
  assign rc = hcm_pkg::red26(key_c);
  assign rd = hcm_pkg::red26(key_d);

  always_ff @(posedge clk) begin
    s1_a  <= ra;
    s1_b  <= rb;
    s1_c  <= rc;
    s1_d  <= rd;
    s1_ad <= 10'(ra) * 10'(rd);
    s1_bc <= 10'(rb) * 10'(rc);
  end

  // Stage 2: determinant modulo 26 and its inverse.
  assign det = hcm_pkg::mod26(11'(s1_ad) + 11'(hcm_pkg::MODULUS * hcm_pkg::MODULUS)
                              - 11'(s1_bc));
  assign inv = hcm_pkg::inv26(det);

  always_ff @(posedge clk) begin
    s2_a  <= s1_a;
    s2_b  <= s1_b;
    s2_c  <= s1_c;
    s2_d  <= s1_d;
    s2_di <= inv.val;
    s2_ok <= inv.ok;
  end

  // Stage 3: scale the adjugate by the inverse determinant.
  always_ff @(posedge clk) begin
    s3_prod[0] <= 10'(s2_di) * 10'(s2_d);
    s3_prod[1] <= 10'(s2_di) * (10'(hcm_pkg::MODULUS) - 10'(s2_b));
    s3_prod[2] <= 10'(s2_di) * (10'(hcm_pkg::MODULUS) - 10'(s2_c));
    s3_prod[3] <= 10'(s2_di) * 10'(s2_a);
    s3_k       <= {s2_d, s2_c, s2_b, s2_a};
    s3_ok      <= s2_ok;
  end

  // Stage 4: pick the key for the current mode; in decrypt mode a singular key reads as zero.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (!decrypt_mode) begin
        s4_k[i] <= s3_k[i];
      end else if (s3_ok) begin
        s4_k[i] <= hcm_pkg::mod26(11'(s3_prod[i]));
      end else begin
        s4_k[i] <= 5'd0;
      end
    end
    s4_err <= decrypt_mode && !s3_ok;
  end

  assign key.k       = s4_k;
  assign key.err     = s4_err;
  assign key.decrypt = decrypt_mode;
  assign key.ready   = (settle == 3'd0);

endmodule

// ----- rtl/hcm_collect.sv -----
module hcm_collect (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [4:0]     letter,
  input  logic           end_of_message,
  input  hcm_pkg::key_t  key,
  output logic           blk_valid,
  input  logic           blk_ready,
  output hcm_pkg::blk_t  blk
);

  logic [1:0]      fill_count;
  logic [2:0][4:0] block_buffer;
  logic [4:0]      lin;
  logic            accept;
  logic            completes;
  logic            emit;
  hcm_pkg::blk_t   blk_next;

  assign lin       = hcm_pkg::red26(letter);
  assign in_ready  = key.ready && (!blk_valid || blk_ready);
  assign accept    = in_valid && in_ready;
  assign completes = (fill_count == 2'd3) || end_of_message;
  // A short block at message end is dropped when decrypting.
  assign emit      = (fill_count == 2'd3) || !key.decrypt;

  // Assemble the block: held letters, then this letter, then padding.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < fill_count) begin
        blk_next.p[i] = block_buffer[2'(i)];
      end else if (2'(i) == fill_count) begin
        blk_next.p[i] = lin;
      end else begin
        blk_next.p[i] = hcm_pkg::PAD_LETTER;
      end
    end
    // The fourth letter is this one only when three are already held.
    blk_next.p[3] = (fill_count == 2'd3) ? lin : hcm_pkg::PAD_LETTER;
    blk_next.eom  = end_of_message;
  end

  // Fill count and the handoff flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= 2'd0;
      blk_valid  <= 1'b0;
    end else begin
      if (blk_ready) begin
        blk_valid <= 1'b0;
      end
      if (accept) begin
        if (completes) begin
          fill_count <= 2'd0;
          if (emit) begin
            blk_valid <= 1'b1;
          end
        end else begin
          fill_count <= fill_count + 2'd1;
        end
      end
    end
  end

  // Letter buffer and block register.
  always_ff @(posedge clk) begin
    if (accept && !completes) begin
      block_buffer[fill_count] <= lin;
    end
    if (accept && completes) begin
      blk <= blk_next;
    end
  end

endmodule

// ----- rtl/hcm_mix.sv -----
module hcm_mix (
  input  logic           clk,
  input  logic           rst,
  input  logic           blk_valid,
  output logic           blk_ready,
  input  hcm_pkg::blk_t  blk,
  input  hcm_pkg::key_t  key,
  output logic           res_valid,
  input  logic           res_ready,
  output hcm_pkg::res_t  res
);

  logic [3:0][10:0] sums;
  logic             sum_eom;
  logic             sum_err;

  assign blk_ready = !res_valid || res_ready;

  // Row times key matrix; each sum is below 2048.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (blk_ready) begin
      res_valid <= blk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_ready && blk_valid) begin
      sums[0] <= 11'(blk.p[0]) * 11'(key.k[0]) + 11'(blk.p[1]) * 11'(key.k[2]);
      sums[1] <= 11'(blk.p[0]) * 11'(key.k[1]) + 11'(blk.p[1]) * 11'(key.k[3]);
      sums[2] <= 11'(blk.p[2]) * 11'(key.k[0]) + 11'(blk.p[3]) * 11'(key.k[2]);
      sums[3] <= 11'(blk.p[2]) * 11'(key.k[1]) + 11'(blk.p[3]) * 11'(key.k[3]);
      sum_eom <= blk.eom;
      sum_err <= key.err;
    end
  end

  // Reduce each sum modulo 26 on the way to the output stage.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res.c[i] = hcm_pkg::mod26(sums[i]);
    end
    res.eom = sum_eom;
    res.err = sum_err;
  end

endmodule

// ----- rtl/hcm_emit.sv -----
module hcm_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  output logic           res_ready,
  input  hcm_pkg::res_t  res,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [4:0]     out_letter,
  output logic           block_last,
  output logic           message_last,
  output logic           key_error
);

  hcm_pkg::res_t held;
  logic [1:0]    idx;
  logic          take;
  logic          load;

  assign take      = out_valid && out_ready;
  assign res_ready = !out_valid || (take && idx == 2'd3);
  assign load      = res_valid && res_ready;

  // Output letter counter and valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
      if (idx == 2'd3) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Block of results being sent.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign out_letter   = held.c[idx];
  assign block_last   = (idx == 2'd3);
  assign message_last = (idx == 2'd3) && held.eom;
  assign key_error    = held.err;

endmodule
